/* rtl/ffazp_pkg.sv */
package ffazp_pkg;

    localparam int ZONE_SLOTS = 4;
    localparam int ZONE_COUNT = 4;
    localparam int ADDR_BITS  = 16;
    localparam int END_BITS   = ADDR_BITS + 1;
    localparam int ZONE_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = END_BITS;
    localparam int S_TDATA_W  = 2 * ADDR_BITS;
    localparam int M_TDATA_W  = ADDR_BITS;
    localparam int M_TUSER_W  = 1 + ZONE_W;

    localparam logic [ZONE_W-1:0] LAST_ZONE = ZONE_W'(ZONE_COUNT - 1);

    // Controller to datapath.
    typedef struct packed {
        logic              load_item;
        logic              commit;
        logic [ZONE_W-1:0] zone;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic fit;
        logic zero_size;
    } dp_status_t;

endpackage

/* rtl/ffazp_datapath.sv */
module ffazp_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [ffazp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ffazp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [ffazp_pkg::S_TDATA_W-1:0]       item_data,
    input  logic                                  item_batch,
    input  ffazp_pkg::ctrl_cmd_t                  cmd,
    output ffazp_pkg::dp_status_t                 status,
    output logic [ffazp_pkg::M_TDATA_W-1:0]       res_data,
    output logic [ffazp_pkg::M_TUSER_W-1:0]       res_user
);

    logic [ffazp_pkg::ADDR_BITS-1:0] zone_start_reg [ffazp_pkg::ZONE_SLOTS];
    logic [ffazp_pkg::END_BITS-1:0]  zone_end_reg   [ffazp_pkg::ZONE_SLOTS];
    logic [ffazp_pkg::ADDR_BITS-1:0] fill_ptr_reg   [ffazp_pkg::ZONE_SLOTS];
    logic [ffazp_pkg::ADDR_BITS-1:0] size_reg;
    logic [ffazp_pkg::ADDR_BITS-1:0] mask_reg;
    logic [ffazp_pkg::M_TDATA_W-1:0] res_data_reg;
    logic [ffazp_pkg::M_TUSER_W-1:0] res_user_reg;

    logic [ffazp_pkg::END_BITS-1:0]  round_sum;
    logic [ffazp_pkg::ADDR_BITS-1:0] aligned_start;
    logic [ffazp_pkg::END_BITS-1:0]  block_end;
    logic [ffazp_pkg::ZONE_W-1:0]    zone_sel;

    assign zone_sel = cmd.zone;

    // Rounding up: adding the complement of the mask and then masking. A carry out
    // of the top bit means the aligned start is past the address space.
    assign round_sum     = {1'b0, fill_ptr_reg[zone_sel]} + {1'b0, ~mask_reg};
    assign aligned_start = round_sum[ffazp_pkg::ADDR_BITS-1:0] & mask_reg;
    assign block_end     = {1'b0, aligned_start} + {1'b0, size_reg};

    assign status.zero_size = (size_reg == '0);
    assign status.fit = !round_sum[ffazp_pkg::ADDR_BITS]
                        && (block_end < zone_end_reg[zone_sel]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ffazp_pkg::ZONE_SLOTS; i++) begin
                zone_start_reg[i] <= '0;
                zone_end_reg[i]   <= '0;
                fill_ptr_reg[i]   <= '0;
            end
        end else begin
            if (cfg_valid && (cfg_index < ffazp_pkg::CFG_IDX_W'(2 * ffazp_pkg::ZONE_SLOTS)))
            begin
                if (cfg_index[0]) begin
                    zone_end_reg[cfg_index[ffazp_pkg::ZONE_W:1]] <= cfg_wdata;
                end else begin
                    zone_start_reg[cfg_index[ffazp_pkg::ZONE_W:1]] <=
                        cfg_wdata[ffazp_pkg::ADDR_BITS-1:0];
                end
            end
            if (cmd.load_item && item_batch) begin
                for (int i = 0; i < ffazp_pkg::ZONE_SLOTS; i++) begin
                    fill_ptr_reg[i] <= zone_start_reg[i];
                end
            end else if (cmd.commit && !status.zero_size && status.fit) begin
                fill_ptr_reg[zone_sel] <= block_end[ffazp_pkg::ADDR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            size_reg <= item_data[ffazp_pkg::ADDR_BITS-1:0];
            mask_reg <= item_data[ffazp_pkg::S_TDATA_W-1:ffazp_pkg::ADDR_BITS];
        end
        if (cmd.commit) begin
            if (status.zero_size) begin
                res_data_reg <= fill_ptr_reg[0];
                res_user_reg <= {{ffazp_pkg::ZONE_W{1'b0}}, 1'b1};
            end else if (status.fit) begin
                res_data_reg <= aligned_start;
                res_user_reg <= {zone_sel, 1'b1};
            end else begin
                res_data_reg <= '0;
                res_user_reg <= '0;
            end
        end
    end

    assign res_data = res_data_reg;
    assign res_user = res_user_reg;

endmodule

/* rtl/ffazp_ctrl.sv */
module ffazp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  ffazp_pkg::dp_status_t  status,
    output ffazp_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                         state_reg;
    logic [ffazp_pkg::ZONE_W-1:0]   zone_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    logic out_free;
    logic scan_done;
    logic accept;

    assign out_free  = !out_valid_reg || m_tready;
    assign scan_done = status.zero_size || status.fit || (zone_reg == ffazp_pkg::LAST_ZONE);
    assign accept    = s_tvalid && (state_reg == ST_IDLE);

    assign s_tready      = (state_reg == ST_IDLE);
    assign m_tvalid      = out_valid_reg;
    assign cmd.load_item = accept;
    assign cmd.commit    = (state_reg == ST_SCAN) && scan_done && out_free;
    assign cmd.zone      = zone_reg;

    // The output register fills on a commit and empties on a result transfer.
    assign out_valid_next = cmd.commit || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            zone_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_IDLE: begin
                    zone_reg <= '0;
                    if (accept) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // A finished scan waits here until the output register is free,
                    // so the pointer update happens only as the result enters the output register.
                    if (scan_done) begin
                        if (out_free) begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        zone_reg <= zone_reg + 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/first_fit_aligned_zone_placer_core.sv */
// Channel | Direction | Handshake          | Contents
// s_      | in        | s_tvalid/s_tready  | tdata: block_size, align_mask; tuser: new_batch
// m_      | out       | m_tvalid/m_tready  | tdata: place_address; tuser: placed, zone_index
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index: register, cfg_wdata: value
//
// An item is taken in by its transfer, then the zones are tried in order, one per cycle,
// through the single rounding adder and end compare, with the result loaded on the
// last of them. A zero-size item or a fit in zone 0 finishes at the zone 0 step.
// Reset (aresetn low, synchronous) clears zone registers and fill pointers to 0.
// A result waiting in the output register does not block the next transfer in; a
// finished scan stalls only while that register is still full and not taken.
module first_fit_aligned_zone_placer_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [15:0] block_size, [31:16] align_mask
    input  logic [ffazp_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] new_batch
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [15:0] place_address
    output logic [ffazp_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] placed, [2:1] zone_index
    output logic [ffazp_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ffazp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffazp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    ffazp_pkg::ctrl_cmd_t  cmd;
    ffazp_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    ffazp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffazp_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_data  (s_tdata),
        .item_batch (s_tuser),
        .cmd        (cmd),
        .status     (status),
        .res_data   (m_tdata),
        .res_user   (m_tuser)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int ZONE_SLOTS      = ffazp_pkg::ZONE_SLOTS;
    localparam int ZONE_COUNT      = ffazp_pkg::ZONE_COUNT;
    localparam int ADDR_BITS       = ffazp_pkg::ADDR_BITS;
    localparam int END_BITS        = ffazp_pkg::END_BITS;
    localparam int ZONE_W          = ffazp_pkg::ZONE_W;
    localparam int CFG_IDX_W       = ffazp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = ffazp_pkg::CFG_DATA_W;
    localparam int S_TDATA_W       = ffazp_pkg::S_TDATA_W;
    localparam int M_TDATA_W       = ffazp_pkg::M_TDATA_W;
    localparam int M_TUSER_W       = ffazp_pkg::M_TUSER_W;

    localparam int REG_COUNT       = 2 * ZONE_SLOTS;
    localparam int START_REG       = 0;
    localparam int END_REG         = 1;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 166;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct packed {
        logic                 placed;
        logic [ZONE_W-1:0]    zone;
        logic [ADDR_BITS-1:0] addr;
    } placement_t;

    typedef enum logic [1:0] {KEEP_ZONES, LOAD_LAYOUT_A, LOAD_LAYOUT_B} zone_step_t;

    typedef struct packed {
        zone_step_t           zones;
        logic [ADDR_BITS-1:0] size;
        logic [ADDR_BITS-1:0] mask;
        logic                 batch;
        logic                 typed;
        placement_t           want;
    } probe_t;

    localparam placement_t NO_PLACE = '{1'b0, 2'd0, 16'h0000};

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Mirror of the zone registers and fill pointers.
    logic [ADDR_BITS-1:0] zone_start [ZONE_SLOTS];
    logic [END_BITS-1:0]  zone_end   [ZONE_SLOTS];
    logic [ADDR_BITS-1:0] fill_ptr   [ZONE_SLOTS];

    placement_t placements [$];
    logic       row_typed;
    placement_t row_want;
    int         errors;
    int         cycles;
    int         gap_pct;
    int         stall_pct;
    bit         calm;

    logic [END_BITS-1:0] layout_a [REG_COUNT] = '{
        17'h00100, 17'h00200, 17'h01000, 17'h01100,
        17'h08000, 17'h0c000, 17'h0ff00, 17'h10000
    };
    logic [END_BITS-1:0] layout_b [REG_COUNT] = '{
        17'h00000, 17'h10000, 17'h0ffff, 17'h10000,
        17'h0ffff, 17'h00000, 17'h00000, 17'h00000
    };

    probe_t directed [19] = '{
        '{KEEP_ZONES,    16'h0000, 16'hffff, 1'b0, 1'b1, '{1'b1, 2'd0, 16'h0000}},
        '{KEEP_ZONES,    16'h0001, 16'hffff, 1'b0, 1'b1, NO_PLACE},
        '{KEEP_ZONES,    16'hffff, 16'h0000, 1'b1, 1'b1, NO_PLACE},
        '{KEEP_ZONES,    16'hffff, 16'hffff, 1'b0, 1'b1, NO_PLACE},
        '{LOAD_LAYOUT_A, 16'h0010, 16'hffff, 1'b1, 1'b1, '{1'b1, 2'd0, 16'h0100}},
        '{KEEP_ZONES,    16'h0000, 16'hff00, 1'b0, 1'b1, '{1'b1, 2'd0, 16'h0110}},
        '{KEEP_ZONES,    16'h0020, 16'hff00, 1'b0, 1'b0, NO_PLACE},
        '{KEEP_ZONES,    16'h0005, 16'hf0f0, 1'b0, 1'b0, NO_PLACE},
        '{KEEP_ZONES,    16'h3fff, 16'hffff, 1'b0, 1'b0, NO_PLACE},
        '{KEEP_ZONES,    16'h00ff, 16'hffff, 1'b0, 1'b0, NO_PLACE},
        '{KEEP_ZONES,    16'h4001, 16'hfff0, 1'b0, 1'b0, NO_PLACE},
        '{KEEP_ZONES,    16'hffff, 16'h0000, 1'b0, 1'b0, NO_PLACE},
        '{KEEP_ZONES,    16'h0001, 16'h0001, 1'b0, 1'b0, NO_PLACE},
        '{KEEP_ZONES,    16'h0000, 16'h0000, 1'b1, 1'b1, '{1'b1, 2'd0, 16'h0100}},
        '{KEEP_ZONES,    16'hffff, 16'hffff, 1'b0, 1'b1, NO_PLACE},
        '{LOAD_LAYOUT_B, 16'hffff, 16'hffff, 1'b1, 1'b1, '{1'b1, 2'd0, 16'h0000}},
        '{KEEP_ZONES,    16'h0001, 16'hffff, 1'b0, 1'b1, NO_PLACE},
        '{KEEP_ZONES,    16'h0000, 16'h0000, 1'b0, 1'b1, '{1'b1, 2'd0, 16'hffff}},
        '{KEEP_ZONES,    16'h0001, 16'hffff, 1'b1, 1'b1, '{1'b1, 2'd0, 16'h0000}}
    };

    first_fit_aligned_zone_placer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // First fit over the active zones; updates the fill pointers.
    function automatic placement_t place_block(input logic [ADDR_BITS-1:0] size,
                                               input logic [ADDR_BITS-1:0] mask,
                                               input logic batch);
        placement_t         res;
        logic [ADDR_BITS:0] rounded;
        logic [ADDR_BITS:0] span;
        int                 z;
        res = NO_PLACE;
        if (batch) begin
            for (z = 0; z < ZONE_SLOTS; z++) fill_ptr[z] = zone_start[z];
        end
        if (size == '0) begin
            res.placed = 1'b1;
            res.addr   = fill_ptr[0];
            return res;
        end
        for (z = 0; z < ZONE_COUNT; z++) begin
            rounded = {1'b0, fill_ptr[z]} + {1'b0, ~mask};
            // A carry out of the address space means this zone cannot take it.
            if (rounded[ADDR_BITS]) continue;
            span = {1'b0, rounded[ADDR_BITS-1:0] & mask} + {1'b0, size};
            if (span < zone_end[z]) begin
                fill_ptr[z] = span[ADDR_BITS-1:0];
                res.placed  = 1'b1;
                res.zone    = ZONE_W'(z);
                res.addr    = rounded[ADDR_BITS-1:0] & mask;
                return res;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin : scoreboard
        placement_t want;
        placement_t seen;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen = '{m_tuser[0], m_tuser[2:1], m_tdata};
                if (placements.size() == 0) begin
                    $error("result transfer with nothing outstanding: address %h", m_tdata);
                    errors++;
                end else begin
                    want = placements.pop_front();
                    if (seen.placed !== want.placed) begin
                        $error("placed: expected %0d, got %0d", want.placed, seen.placed);
                        errors++;
                    end
                    if (seen.zone !== want.zone) begin
                        $error("zone_index: expected %0d, got %0d", want.zone, seen.zone);
                        errors++;
                    end
                    if (seen.addr !== want.addr) begin
                        $error("place_address: expected %h, got %h", want.addr, seen.addr);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready && cfg_index < REG_COUNT) begin
                if (cfg_index[0] == END_REG[0]) begin
                    zone_end[cfg_index >> 1] = cfg_wdata;
                end else begin
                    zone_start[cfg_index >> 1] = cfg_wdata[ADDR_BITS-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                want = place_block(s_tdata[ADDR_BITS-1:0], s_tdata[2*ADDR_BITS-1:ADDR_BITS],
                                   s_tuser);
                if (row_typed) want = row_want;
                placements.insert(placements.size(), want);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver back-pressure: random stalls of random length, none while calm.
    initial begin : receiver
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (calm) begin
                m_tready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(99) < stall_pct) begin
                m_tready <= 1'b0;
                hold = $urandom_range(7);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic send_block(input logic [ADDR_BITS-1:0] size, input logic [ADDR_BITS-1:0] mask,
                              input logic batch, input logic typed, input placement_t want);
        s_tdata   <= {mask, size};
        s_tuser   <= batch;
        s_tvalid  <= 1'b1;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
        if (!calm && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (placements.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes every zone register back to back, then one random index past the last.
    task automatic program_zones(input logic [END_BITS-1:0] regs [REG_COUNT]);
        int i;
        for (i = 0; i <= REG_COUNT; i++) begin
            if (i == REG_COUNT) begin
                cfg_index <= CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1));
                cfg_wdata <= CFG_DATA_W'($urandom);
            end else begin
                cfg_index <= CFG_IDX_W'(i);
                cfg_wdata <= regs[i];
            end
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!(cfg_valid && cfg_ready));
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [END_BITS-1:0]  regs [REG_COUNT];
        logic [ADDR_BITS-1:0] size;
        logic [ADDR_BITS-1:0] mask;
        logic                 batch;
        int                   base;
        int                   phase;
        int                   n;
        int                   z;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        row_typed = 1'b0;
        row_want  = NO_PLACE;
        errors    = 0;
        cycles    = 0;
        calm      = 1'b0;
        gap_pct   = 30;
        stall_pct = 30;
        for (z = 0; z < ZONE_SLOTS; z++) begin
            zone_start[z] = '0;
            zone_end[z]   = '0;
            fill_ptr[z]   = '0;
        end

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[r]) begin
            if (directed[r].zones == LOAD_LAYOUT_A) begin
                settle();
                program_zones(layout_a);
            end else if (directed[r].zones == LOAD_LAYOUT_B) begin
                settle();
                program_zones(layout_b);
            end
            send_block(directed[r].size, directed[r].mask, directed[r].batch,
                       directed[r].typed, directed[r].want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            if (phase % 2 == 0) begin
                // Zones laid out in rising order, possibly with gaps between them.
                base = $urandom_range(16'h3000);
                for (z = 0; z < ZONE_SLOTS; z++) begin
                    regs[2 * z + START_REG] = END_BITS'(base);
                    base = base + $urandom_range(16'h40, 16'h2000);
                    regs[2 * z + END_REG] = END_BITS'(base);
                    base = base + $urandom_range(16'h400);
                end
            end else begin
                // Arbitrary zones; the top bit of a start value must be dropped.
                for (z = 0; z < ZONE_SLOTS; z++) begin
                    regs[2 * z + START_REG] = END_BITS'($urandom);
                    regs[2 * z + END_REG] = ($urandom_range(3) == 0) ? 17'h10000 :
                        END_BITS'($urandom_range(17'h10000));
                end
            end
            program_zones(regs);
            calm      = (phase == PHASES - 1);
            gap_pct   = (phase % 3 == 1) ? 0 : 25;
            stall_pct = (phase % 3 == 2) ? 0 : 25;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 2 && n == ITEMS_PER_PHASE / 2) settle();
                if ($urandom_range(99) < 15) begin
                    size  = ADDR_BITS'($urandom);
                    mask  = ADDR_BITS'($urandom);
                    batch = 1'($urandom);
                end else begin
                    mask  = 16'hffff << $urandom_range(10);
                    size  = ($urandom_range(19) == 0) ? '0 : ADDR_BITS'($urandom_range(1, 16'h200));
                    batch = (n == 0) || ($urandom_range(39) == 0);
                end
                send_block(size, mask, batch, 1'b0, NO_PLACE);
            end
        end

        settle();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ffazp_pkg.sv
rtl/ffazp_datapath.sv
rtl/ffazp_ctrl.sv
rtl/first_fit_aligned_zone_placer_core.sv
test/tb.sv
